[rtl/rs485_frame_receiver_macros.svh]
// assertion macros used by the rtl
`ifndef RS485_FRAME_RECEIVER_MACROS_SVH
`define RS485_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RSFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RSFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RSFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define RSFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/rsfr_pkg.sv]
package rsfr_pkg;

    localparam logic [7:0] HEAD_MARK      = 8'hF7;
    localparam logic [7:0] TYPE_DATA      = 8'h10;
    localparam logic [7:0] TYPE_REALTIME  = 8'h30;
    localparam logic [7:0] TAIL_MARK      = 8'hEE;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd7;

    typedef enum logic [2:0] {
        ST_BYTE       = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_BAD_TYPE   = 3'd2,
        ST_BAD_TAIL   = 3'd3,
        ST_REALTIME   = 3'd4,
        ST_TOO_LONG   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR
    } t_state;

endpackage

[rtl/rsfr_store.sv]
module rsfr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rsfr_ctrl.sv]
`include "rs485_frame_receiver_macros.svh"

module rsfr_ctrl
    import rsfr_pkg::*;
#(
    parameter int BUFFER_BYTES = 64,
    parameter int AW           = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_parse_enable,
    input  logic          i_rx_valid,
    output logic          o_rx_ready,
    input  logic [7:0]    i_rx_byte,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_frame_byte,
    output logic [2:0]    o_status,
    output logic          o_last,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [7:0]    o_mem_wdata,
    output logic          o_mem_re,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [7:0]    i_mem_rdata
);

    localparam int CW = AW + 1;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_parse_en;
    logic [7:0]    r_type, n_type;
    logic [CW-1:0] r_total, n_total;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_ov, n_ov;
    logic [7:0]    r_byte, n_byte;
    t_status       r_status, n_status;
    logic          r_last, n_last;

    logic          w_take;
    logic [AW-1:0] w_at;
    logic [CW-1:0] w_cnt;
    logic [8:0]    w_len_total;
    logic          w_emit;
    logic          w_drain;
    t_status       w_code;
    logic          w_out_free;
    logic          w_last_rd;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_ov || i_out_ready;
    assign o_rx_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_take      = i_rx_valid && o_rx_ready;

    // guard: a count at the buffer size restarts the frame
    assign w_at = (r_count >= CW'(BUFFER_BYTES)) ? '0 : r_count[AW-1:0];
    assign w_cnt = {1'b0, w_at} + CW'(1);
    assign w_len_total = {1'b0, i_rx_byte} + {1'b0, FRAME_OVERHEAD};
    assign w_last_rd = (({1'b0, r_idx} + CW'(1)) == r_total);

    assign o_mem_we    = w_take && r_parse_en;
    assign o_mem_waddr = w_at;
    assign o_mem_wdata = i_rx_byte;
    assign o_mem_re    = (r_state == S_RD);
    assign o_mem_raddr = r_idx;

    // frame checks on the word being stored
    always_comb begin
        w_emit  = 1'b0;
        w_drain = 1'b0;
        w_code  = ST_BYTE;
        if (w_at == '0) begin
            if (i_rx_byte != HEAD_MARK) begin
                w_emit = 1'b1;
                w_code = ST_BAD_HEADER;
            end
        end else if (w_at == AW'(2)) begin
            if (!(r_type inside {TYPE_DATA, TYPE_REALTIME})) begin
                w_emit = 1'b1;
                w_code = ST_BAD_TYPE;
            end
        end else if (w_at == AW'(4)) begin
            if (w_len_total > 9'(BUFFER_BYTES)) begin
                w_emit = 1'b1;
                w_code = ST_TOO_LONG;
            end
        end else if (w_at > AW'(4) && w_cnt == r_total) begin
            if (r_type == TYPE_REALTIME) begin
                w_emit = 1'b1;
                w_code = ST_REALTIME;
            end else if (i_rx_byte != TAIL_MARK) begin
                w_emit = 1'b1;
                w_code = ST_BAD_TAIL;
            end else begin
                w_drain = 1'b1;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_type   = r_type;
        n_total  = r_total;
        n_idx    = r_idx;
        n_ov     = r_ov;
        n_byte   = r_byte;
        n_status = r_status;
        n_last   = r_last;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_take && r_parse_en) begin
                    n_count = (w_emit || w_drain) ? '0 : w_cnt;
                    if (w_at == AW'(1)) begin
                        n_type = i_rx_byte;
                    end
                    if (w_at == AW'(4)) begin
                        n_total = w_len_total[CW-1:0];
                    end
                    if (w_emit) begin
                        n_ov     = 1'b1;
                        n_byte   = '0;
                        n_status = w_code;
                        n_last   = 1'b1;
                    end
                    if (w_drain) begin
                        n_idx   = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (w_out_free) begin
                    n_ov     = 1'b1;
                    n_byte   = i_mem_rdata;
                    n_status = ST_BYTE;
                    n_last   = w_last_rd;
                    if (w_last_rd) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ov       <= 1'b0;
            r_parse_en <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_parse_en <= i_cfg_parse_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_total  <= n_total;
        r_idx    <= n_idx;
        r_byte   <= n_byte;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_out_valid  = r_ov;
    assign o_frame_byte = r_byte;
    assign o_status     = r_status;
    assign o_last       = r_last;

    `RSFR_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count < CW'(BUFFER_BYTES), "count reached buffer size")
    `RSFR_ASSERT_IMP(a_drain_count_zero, i_clk, i_rst_n, r_state != S_IDLE, r_count == '0, "count not cleared during drain")
    `RSFR_ASSERT_IMP(a_drain_idx, i_clk, i_rst_n, r_state != S_IDLE, ({1'b0, r_idx} < r_total), "drain index past frame end")
    `RSFR_ASSERT_IMP(a_status_last, i_clk, i_rst_n, r_ov && r_status != ST_BYTE, r_last, "status word not marked last")
    `RSFR_ASSERT_NXT(a_drain_start, i_clk, i_rst_n, w_take && r_parse_en && w_drain, r_state == S_RD && r_count == '0, "drain did not start")

endmodule

[rtl/rs485_frame_receiver.sv]
// channel  | valid       | ready       | data
// rx       | i_rx_valid  | o_rx_ready  | i_rx_byte
// out      | o_out_valid | i_out_ready | o_frame_byte, o_status, o_last
// cfg      | i_cfg_valid | o_cfg_ready | i_cfg_parse_enable
//
// a received word is taken while the receiver is idle and the output register is free or
// being emptied; with parsing enabled it is written straight into the frame memory
// a good data frame drains one byte at a time, each by a memory read, then an output load
// that waits on a free output; rx stays stalled until the drain ends
// rx ready drops while any output word waits on a stalled output
// synchronous active-low reset clears control only; frame memory needs no clearing
module rs485_frame_receiver
    import rsfr_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_parse_enable,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_frame_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [7:0]    w_mem_wdata;
    logic          w_mem_re;
    logic [AW-1:0] w_mem_raddr;
    logic [7:0]    w_mem_rdata;

    rsfr_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_parse_enable (i_cfg_parse_enable),
        .i_rx_valid         (i_rx_valid),
        .o_rx_ready         (o_rx_ready),
        .i_rx_byte          (i_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_frame_byte       (o_frame_byte),
        .o_status           (o_status),
        .o_last             (o_last),
        .o_mem_we           (w_mem_we),
        .o_mem_waddr        (w_mem_waddr),
        .o_mem_wdata        (w_mem_wdata),
        .o_mem_re           (w_mem_re),
        .o_mem_raddr        (w_mem_raddr),
        .i_mem_rdata        (w_mem_rdata)
    );

    rsfr_store #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
    import rsfr_pkg::*;
;

    localparam int FRAME_BUF = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES = 40;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] st;
        logic       last;
    } t_word;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_parse_enable = 1'b0;
    logic       rx_valid = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       out_ready = 1'b0;
    logic       o_cfg_ready;
    logic       o_rx_ready;
    logic       o_out_valid;
    logic [7:0] o_frame_byte;
    logic [2:0] o_status;
    logic       o_last;

    // frame predictor state
    logic [7:0]  frame_img [FRAME_BUF];
    int unsigned frame_fill = 0;
    bit          parse_on = 1'b0;
    t_word       expected_words [$];

    int unsigned words_parsed = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    bit          no_idle = 1'b0;
    t_word       oldest;
    t_word       got;

    always #2 clk = ~clk;

    rs485_frame_receiver #(
        .BUFFER_BYTES(FRAME_BUF)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_parse_enable(cfg_parse_enable),
        .i_rx_valid        (rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_frame_byte      (o_frame_byte),
        .o_status          (o_status),
        .o_last            (o_last)
    );

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic void drop_frame(input t_status code);
        t_word w;
        w.data = 8'h00;
        w.st = code;
        w.last = 1'b1;
        expected_words.push_back(w);
        frame_fill = 0;
    endfunction

    function automatic void predict_rx(input logic [7:0] b);
        int unsigned total;
        t_word w;
        if (!parse_on)
            return;
        if (frame_fill >= FRAME_BUF)
            frame_fill = 0;
        frame_img[frame_fill] = b;
        frame_fill = (frame_fill + 1) & 32'h7F;
        if (frame_img[0] != HEAD_MARK) begin
            drop_frame(ST_BAD_HEADER);
            return;
        end
        if (frame_fill < 3)
            return;
        if (!(frame_img[1] inside {TYPE_DATA, TYPE_REALTIME})) begin
            drop_frame(ST_BAD_TYPE);
            return;
        end
        if (frame_fill < 5)
            return;
        total = int'(frame_img[4]) + int'(FRAME_OVERHEAD);
        if (total > FRAME_BUF) begin
            drop_frame(ST_TOO_LONG);
            return;
        end
        if (frame_fill < total)
            return;
        if (frame_img[1] == TYPE_REALTIME) begin
            drop_frame(ST_REALTIME);
            return;
        end
        if (frame_img[total - 1] != TAIL_MARK) begin
            drop_frame(ST_BAD_TAIL);
            return;
        end
        for (int unsigned k = 0; k < total; k++) begin
            w.data = frame_img[k];
            w.st = ST_BYTE;
            w.last = (k + 1 == total);
            expected_words.push_back(w);
        end
        frame_fill = 0;
    endfunction

    task automatic send_word(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            rx_valid <= 1'b0;
        end
        @(negedge clk);
        rx_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!o_rx_ready);
        if (parse_on)
            words_parsed++;
        predict_rx(b);
    endtask

    // sends a frame only up to the byte on which the block drops it
    task automatic send_frame(input logic [7:0] kind, input int unsigned len,
                              input logic [7:0] tail);
        int unsigned total;
        int unsigned stop;
        logic [7:0] b;
        total = len + 7;
        if (!(kind inside {TYPE_DATA, TYPE_REALTIME}))
            stop = 3;
        else if (total > FRAME_BUF)
            stop = 5;
        else
            stop = total;
        for (int unsigned k = 0; k < stop; k++) begin
            if (k == 0)
                b = HEAD_MARK;
            else if (k == 1)
                b = kind;
            else if (k == 4)
                b = len[7:0];
            else if (k == total - 1)
                b = tail;
            else
                b = 8'($urandom);
            send_word(b);
        end
    endtask

    // idle rx, wait out all results and any byte still being stored
    task automatic settle();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_parse_enable(input bit en);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_parse_enable <= en;
        do @(posedge clk); while (!o_cfg_ready);
        parse_on = en;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_ignored_while_disabled();
        send_frame(TYPE_DATA, 0, TAIL_MARK);
        repeat (3) send_word(8'($urandom));
    endtask

    task automatic test_bad_header();
        send_word(8'h00);
        send_word(8'hFF);
        send_word(TAIL_MARK);
    endtask

    task automatic test_bad_type();
        send_frame(8'h00, 0, TAIL_MARK);
        send_frame(8'hFF, 0, TAIL_MARK);
        send_frame(HEAD_MARK, 0, TAIL_MARK);
    endtask

    task automatic test_length_limit();
        send_frame(TYPE_DATA, FRAME_BUF - 6, TAIL_MARK);
        send_frame(TYPE_REALTIME, 255, TAIL_MARK);
    endtask

    task automatic test_frame_outcomes();
        send_frame(TYPE_DATA, 0, TAIL_MARK);
        send_frame(TYPE_DATA, 0, 8'h00);
        send_frame(TYPE_REALTIME, 2, TAIL_MARK);
    endtask

    task automatic test_longest_frames();
        send_frame(TYPE_DATA, FRAME_BUF - 7, TAIL_MARK);
    endtask

    // parsing switched off in the middle of a frame must keep the partial frame
    task automatic test_paused_frame();
        send_word(HEAD_MARK);
        send_word(TYPE_DATA);
        send_word(8'h00);
        send_word(8'hFF);
        write_parse_enable(1'b0);
        repeat (5) send_word(8'($urandom));
        write_parse_enable(1'b1);
        send_word(8'd3);
        repeat (4) send_word(8'($urandom));
        send_word(TAIL_MARK);
    endtask

    task automatic test_random_traffic(input int unsigned n_words);
        int unsigned goal;
        int unsigned pick;
        int unsigned len;
        logic [7:0] kind;
        logic [7:0] tail;
        goal = words_parsed + n_words;
        while (words_parsed < goal) begin
            no_idle = ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 3)) send_word(8'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                kind = (pick < 75) ? TYPE_DATA : (pick < 92) ? TYPE_REALTIME : 8'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    len = $urandom_range(0, 8);
                else if (pick < 95)
                    len = $urandom_range(9, FRAME_BUF - 7);
                else
                    len = $urandom_range(FRAME_BUF - 6, 255);
                tail = ($urandom_range(0, 99) < 85) ? TAIL_MARK : 8'($urandom);
                send_frame(kind, len, tail);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : out_side
        int unsigned gap;
        wait (rst_n);
        forever begin
            gap = pick_gap();
            repeat (gap) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(o_out_valid && out_ready));
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            got = {o_frame_byte, o_status, o_last};
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word data=%h status=%0d last=%b",
                         $time, got.data, got.st, got.last);
                mismatches++;
            end else begin
                oldest = expected_words.pop_front();
                if (got !== oldest) begin
                    $display("%0t: expected %h/%0d/%b, got %h/%0d/%b",
                             $time, oldest.data, oldest.st, oldest.last,
                             got.data, got.st, got.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (rx_valid && o_rx_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[rs485_frame_receiver] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ignored_while_disabled();
        write_parse_enable(1'b1);
        test_bad_header();
        test_bad_type();
        test_length_limit();
        test_frame_outcomes();
        test_longest_frames();
        test_paused_frame();
        test_random_traffic(43);
        write_parse_enable(1'b0);
        test_ignored_while_disabled();
        write_parse_enable(1'b1);
        test_random_traffic(43);

        settle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[rs485_frame_receiver] OK");
        else
            $display("[rs485_frame_receiver] ERROR");
        $finish;
    end

endmodule
